/* src/ilha_pkg.sv */
`timescale 1ns / 1ps
package ilha_pkg;
    localparam int HeapBytes = 65536;
    localparam int TagWords = HeapBytes / 4;
    localparam int AW = $clog2(TagWords);
    localparam int BW = 17;
    localparam int DW = 17;
    localparam logic [BW-1:0] HEAP_LIMIT = BW'(HeapBytes);
    localparam logic [BW-1:0] INIT_EXTEND = BW'(1 << 12);
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OOM = 2'd2;
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    typedef struct packed {
        logic we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

    function automatic logic [AW-1:0] widx(input logic [BW-1:0] a);
        widx = a[AW+1:2];
    endfunction
endpackage

/* src/ilha_if.sv */
`timescale 1ns / 1ps
interface ilha_req_if;
    logic valid;
    logic ready;
    logic op;
    logic [16:0] request_bytes;
    logic [15:0] block_address;
    modport source (output valid, op, request_bytes, block_address, input ready);
    modport sink (input valid, op, request_bytes, block_address, output ready);
endinterface

interface ilha_rsp_if;
    logic valid;
    logic ready;
    logic [15:0] payload_address;
    logic [1:0] status;
    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

interface ilha_cfg_if;
    logic valid;
    logic ready;
    logic [16:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* src/ilha_tag_ram.sv */
`timescale 1ns / 1ps
module ilha_tag_ram
    import ilha_pkg::*;
(
    input  logic clk,
    input  mem_req_t req,
    output logic [DW-1:0] rdata
);
    logic [DW-1:0] mem [TagWords];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end
endmodule

/* src/ilha_ctrl.sv */
`timescale 1ns / 1ps
module ilha_ctrl
    import ilha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ilha_req_if.sink req,
    ilha_rsp_if.source rsp,
    ilha_cfg_if.sink cfg,
    output mem_req_t mreq,
    input  logic [DW-1:0] rdata
);
    typedef enum logic [15:0] {
        S_CLR  = 16'b0000000000000001,
        S_IDLE = 16'b0000000000000010,
        S_WALK = 16'b0000000000000100,
        S_WCHK = 16'b0000000000001000,
        S_GROW = 16'b0000000000010000,
        S_MPRV = 16'b0000000000100000,
        S_MPRD = 16'b0000000001000000,
        S_MNXT = 16'b0000000010000000,
        S_MNXD = 16'b0000000100000000,
        S_MPPR = 16'b0000001000000000,
        S_MPPD = 16'b0000010000000000,
        S_WR   = 16'b0000100000000000,
        S_PLC  = 16'b0001000000000000,
        S_RSP  = 16'b0010000000000000,
        S_INIT = 16'b0100000000000000,
        S_PLCD = 16'b1000000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [BW-1:0] extend_reg, extend_next;
    logic [BW-1:0] brk_reg, brk_next;
    logic op_reg, op_next;
    logic [BW-1:0] asize_reg, asize_next;
    logic [BW-1:0] addr_reg, addr_next;
    logic [BW-1:0] bp_reg, bp_next;
    logic [BW-1:0] size_reg, size_next;
    logic [BW-1:0] prv_reg, prv_next;
    logic prvu_reg, prvu_next;
    logic [BW-1:0] nsz_reg, nsz_next;
    logic nxtu_reg, nxtu_next;
    logic [BW-1:0] wa_reg [4];
    logic [BW-1:0] wa_next [4];
    logic [DW-1:0] wd_reg [4];
    logic [DW-1:0] wd_next [4];
    logic [2:0] wn_reg, wn_next;
    logic [1:0] wi_reg, wi_next;
    logic [1:0] ret_reg, ret_next;
    logic [15:0] pa_reg, pa_next;
    logic [1:0] st_reg, st_next;
    logic placed_reg, placed_next;

    localparam logic [1:0] R_PLACE = 2'd0;
    localparam logic [1:0] R_DONE = 2'd1;
    localparam logic [1:0] R_INIT = 2'd2;

    logic [BW-1:0] rsz;
    logic rused;
    logic [BW:0] want, gsz, room;
    logic [BW:0] rq_sum;
    logic [BW-1:0] rq_round;

    assign rsz = {rdata[BW-1:3], 3'b000};
    assign rused = rdata[0];
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RSP);
    assign rsp.payload_address = pa_reg;
    assign rsp.status = st_reg;
    assign rq_sum = ({1'b0, req.request_bytes} + 18'd15) & ~18'd7;
    // oversized requests saturate so that they can never fit
    assign rq_round = rq_sum[BW] ? {{(BW-3){1'b1}}, 3'b000} : rq_sum[BW-1:0];

    always_comb
    begin
        want = (asize_reg > extend_reg) ? {1'b0, asize_reg} : {1'b0, extend_reg};
        gsz = ((want >> 2) + 18'd1) & ~18'd1;
        gsz = gsz << 2;
        room = (BW + 1)'(HeapBytes) - {1'b0, brk_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        extend_next = extend_reg;
        brk_next = brk_reg;
        op_next = op_reg;
        asize_next = asize_reg;
        addr_next = addr_reg;
        bp_next = bp_reg;
        size_next = size_reg;
        prv_next = prv_reg;
        prvu_next = prvu_reg;
        nsz_next = nsz_reg;
        nxtu_next = nxtu_reg;
        wa_next = wa_reg;
        wd_next = wd_reg;
        wn_next = wn_reg;
        wi_next = wi_reg;
        ret_next = ret_reg;
        pa_next = pa_reg;
        st_next = st_reg;
        placed_next = placed_reg;
        mreq = '0;
        if (cfg.valid && cfg.ready)
        begin
            extend_next = cfg.data;
        end
        unique case (state_reg)
            S_CLR:
            begin
                mreq.we = 1'b1;
                mreq.waddr = clr_reg;
                mreq.wdata = '0;
                // prologue header and footer, epilogue
                if (clr_reg == AW'(1) || clr_reg == AW'(2))
                begin
                    mreq.wdata = DW'(9);
                end
                else if (clr_reg == AW'(3))
                begin
                    mreq.wdata = DW'(1);
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == AW'(TagWords - 1))
                begin
                    brk_next = BW'(16);
                    asize_next = '0;
                    extend_next = INIT_EXTEND;
                    ret_next = R_INIT;
                    state_next = S_GROW;
                end
            end
            S_INIT:
            begin
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.op;
                    pa_next = '0;
                    st_next = ST_DONE;
                    placed_next = 1'b0;
                    addr_next = {1'b0, req.block_address};
                    bp_next = BW'(16);
                    asize_next = (req.request_bytes <= 17'd8) ? BW'(16) : rq_round;
                    if (req.op == OP_ALLOC && req.request_bytes == '0)
                    begin
                        st_next = ST_ZERO;
                        state_next = S_RSP;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                mreq.raddr = widx(bp_reg - BW'(4));
                if (bp_reg >= brk_reg)
                begin
                    state_next = (op_reg == OP_ALLOC) ? S_GROW : S_RSP;
                    ret_next = R_PLACE;
                end
                else if (op_reg == OP_FREE && bp_reg > addr_reg)
                begin
                    state_next = S_RSP;
                end
                else
                begin
                    state_next = S_WCHK;
                end
            end
            S_WCHK:
            begin
                size_next = rsz;
                if (rsz == '0)
                begin
                    ret_next = R_PLACE;
                    state_next = (op_reg == OP_ALLOC) ? S_GROW : S_RSP;
                end
                else if (op_reg == OP_ALLOC)
                begin
                    if (!rused && rsz >= asize_reg)
                    begin
                        state_next = S_PLC;
                    end
                    else
                    begin
                        bp_next = bp_reg + rsz;
                        state_next = S_WALK;
                    end
                end
                else if (bp_reg == addr_reg)
                begin
                    ret_next = R_DONE;
                    state_next = rused ? S_MPRV : S_RSP;
                end
                else
                begin
                    bp_next = bp_reg + rsz;
                    state_next = S_WALK;
                end
            end
            S_GROW:
            begin
                if (gsz == '0 || gsz > room)
                begin
                    st_next = ST_OOM;
                    state_next = (ret_reg == R_INIT) ? S_INIT : S_RSP;
                end
                else
                begin
                    bp_next = brk_reg;
                    size_next = BW'(gsz);
                    brk_next = brk_reg + BW'(gsz);
                    // new free block and epilogue written before the merge
                    wa_next[0] = brk_reg - BW'(4);
                    wd_next[0] = DW'(gsz);
                    wa_next[1] = brk_reg + BW'(gsz) - BW'(8);
                    wd_next[1] = DW'(gsz);
                    wa_next[2] = brk_reg + BW'(gsz) - BW'(4);
                    wd_next[2] = DW'(1);
                    wn_next = 3'd3;
                    wi_next = '0;
                    placed_next = 1'b1;
                    state_next = S_WR;
                end
            end
            S_MPRV:
            begin
                mreq.raddr = widx(bp_reg - BW'(8));
                state_next = S_MPRD;
            end
            S_MPRD:
            begin
                prvu_next = rdata[0];
                prv_next = bp_reg - rsz;
                state_next = S_MNXT;
            end
            S_MNXT:
            begin
                mreq.raddr = widx(bp_reg + size_reg - BW'(4));
                state_next = S_MNXD;
            end
            S_MNXD:
            begin
                nsz_next = rsz;
                nxtu_next = rused;
                state_next = S_MPPR;
            end
            S_MPPR:
            begin
                mreq.raddr = widx(prv_reg - BW'(4));
                state_next = S_MPPD;
            end
            S_MPPD:
            begin
                wi_next = '0;
                if (prvu_reg && nxtu_reg)
                begin
                    wa_next[0] = bp_reg - BW'(4);
                    wd_next[0] = DW'(size_reg);
                    wa_next[1] = bp_reg + size_reg - BW'(8);
                    wd_next[1] = DW'(size_reg);
                    wn_next = 3'd2;
                end
                else if (prvu_reg)
                begin
                    wa_next[0] = bp_reg - BW'(4);
                    wd_next[0] = DW'(size_reg + nsz_reg);
                    wa_next[1] = bp_reg + size_reg + nsz_reg - BW'(8);
                    wd_next[1] = DW'(size_reg + nsz_reg);
                    wn_next = 3'd2;
                end
                else
                begin
                    size_next = size_reg + rsz + (nxtu_reg ? BW'(0) : nsz_reg);
                    wa_next[0] = prv_reg - BW'(4);
                    wd_next[0] = DW'(size_next);
                    wa_next[1] = prv_reg + size_next - BW'(8);
                    wd_next[1] = DW'(size_next);
                    wn_next = 3'd2;
                    bp_next = prv_reg;
                end
                if (!prvu_reg && !nxtu_reg)
                begin
                    size_next = size_reg + rsz + nsz_reg;
                end
                else if (prvu_reg && !nxtu_reg)
                begin
                    size_next = size_reg + nsz_reg;
                end
                placed_next = 1'b0;
                state_next = S_WR;
            end
            S_WR:
            begin
                mreq.we = 1'b1;
                mreq.waddr = widx(wa_reg[wi_reg]);
                mreq.wdata = wd_reg[wi_reg];
                wi_next = wi_reg + 1'b1;
                if (3'(wi_reg) + 3'd1 == wn_reg)
                begin
                    if (placed_reg)
                    begin
                        // freshly grown block goes through the merge
                        placed_next = 1'b0;
                        state_next = S_MPRV;
                    end
                    else if (op_reg == OP_FREE && ret_reg == R_DONE)
                    begin
                        state_next = S_RSP;
                    end
                    else if (ret_reg == R_INIT)
                    begin
                        state_next = S_INIT;
                    end
                    else if (ret_reg == R_PLACE)
                    begin
                        state_next = S_PLC;
                    end
                    else
                    begin
                        state_next = S_RSP;
                    end
                end
            end
            S_PLC:
            begin
                pa_next = bp_reg[15:0];
                ret_next = R_DONE;
                op_next = OP_ALLOC;
                wi_next = '0;
                if (size_reg - asize_reg < BW'(8))
                begin
                    wa_next[0] = bp_reg - BW'(4);
                    wd_next[0] = DW'(size_reg | BW'(1));
                    wa_next[1] = bp_reg + size_reg - BW'(8);
                    wd_next[1] = DW'(size_reg | BW'(1));
                    wn_next = 3'd2;
                end
                else
                begin
                    wa_next[0] = bp_reg - BW'(4);
                    wd_next[0] = DW'(asize_reg | BW'(1));
                    wa_next[1] = bp_reg + asize_reg - BW'(8);
                    wd_next[1] = DW'(asize_reg | BW'(1));
                    wa_next[2] = bp_reg + asize_reg - BW'(4);
                    wd_next[2] = DW'(size_reg - asize_reg);
                    wa_next[3] = bp_reg + size_reg - BW'(8);
                    wd_next[3] = DW'(size_reg - asize_reg);
                    wn_next = 3'd4;
                end
                state_next = S_PLCD;
            end
            S_PLCD:
            begin
                state_next = S_WR;
            end
            S_RSP:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_WCHK && op_reg == OP_FREE && bp_reg == addr_reg && rsz != '0
            && rused)
        begin
            // write the freed header and footer through the merge path
            size_next = rsz;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            extend_reg <= INIT_EXTEND;
            brk_reg <= BW'(16);
            op_reg <= OP_ALLOC;
            ret_reg <= R_INIT;
            placed_reg <= 1'b0;
            wn_reg <= '0;
            wi_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            extend_reg <= extend_next;
            brk_reg <= brk_next;
            op_reg <= op_next;
            ret_reg <= ret_next;
            placed_reg <= placed_next;
            wn_reg <= wn_next;
            wi_reg <= wi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        asize_reg <= asize_next;
        addr_reg <= addr_next;
        bp_reg <= bp_next;
        size_reg <= size_next;
        prv_reg <= prv_next;
        prvu_reg <= prvu_next;
        nsz_reg <= nsz_next;
        nxtu_reg <= nxtu_next;
        wa_reg <= wa_next;
        wd_reg <= wd_next;
        pa_reg <= pa_next;
        st_reg <= st_next;
    end
endmodule

/* src/implicit_list_heap_allocator.sv */
`timescale 1ns / 1ps
// operation: the walk visits the blocks in order, then an allocation is placed (growing the
// heap first when no free block fits) or a free is merged, then the result is given
// throughput: one item at a time; the next item is accepted once the result is taken
// reset: a clearing pass writes the tag memory, then the initial free block is built;
// no item is accepted until then
module implicit_list_heap_allocator
    import ilha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    ilha_req_if.sink req,
    ilha_rsp_if.source rsp,
    ilha_cfg_if.sink cfg
);
    mem_req_t mreq;
    logic [DW-1:0] rdata;

    ilha_tag_ram u_ram (
        .clk   (clk),
        .req   (mreq),
        .rdata (rdata)
    );

    ilha_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .mreq  (mreq),
        .rdata (rdata)
    );
endmodule

/* verif/tb_implicit_list_heap_allocator.sv */
`timescale 1ns / 1ps
module tb_implicit_list_heap_allocator;
    import ilha_pkg::*;

    localparam int WatchdogLimit = 150000;
    localparam int RandomItems = 1700;

    typedef struct {
        logic [15:0] addr;
        logic [1:0] status;
    } heap_result_t;

    // tracks the expected heap and the results it produces
    class heap_scoreboard;
        bit [16:0] tags [TagWords];
        int unsigned brk;
        int unsigned extend;
        bit [15:0] live_blocks[$];
        bit [15:0] last_alloc;
        heap_result_t pending_q[$];
        int errors;

        function new();
            int unsigned bp;
            foreach (tags[i]) tags[i] = '0;
            tag_wr(4, 9);
            tag_wr(8, 9);
            tag_wr(12, 1);
            brk = 16;
            extend = 4096;
            void'(grow(64'(INIT_EXTEND), bp));
            errors = 0;
        endfunction

        function int unsigned tag_rd(int unsigned a);
            int unsigned i;
            i = a >> 2;
            return (i < TagWords) ? int'(tags[i]) : 0;
        endfunction

        function void tag_wr(int unsigned a, int unsigned v);
            int unsigned i;
            i = a >> 2;
            if (i < TagWords)
                tags[i] = v[16:0];
        endfunction

        function int unsigned bsize(int unsigned bp);
            return tag_rd(bp - 4) & ~32'h7;
        endfunction

        function int unsigned bused(int unsigned bp);
            return tag_rd(bp - 4) & 1;
        endfunction

        function void bset(int unsigned bp, int unsigned sz, int unsigned used);
            tag_wr(bp - 4, sz | used);
            tag_wr(bp + sz - 8, sz | used);
        endfunction

        function int unsigned merge(int unsigned bp);
            int unsigned sz, prev_used, nxt, next_used, prev;
            sz = bsize(bp);
            prev_used = tag_rd(bp - 8) & 1;
            nxt = bp + sz;
            next_used = bused(nxt);
            prev = bp - (tag_rd(bp - 8) & ~32'h7);
            if (prev_used && next_used)
                return bp;
            if (prev_used)
            begin
                sz += bsize(nxt);
                bset(bp, sz, 0);
                return bp;
            end
            sz += bsize(prev);
            if (!next_used)
                sz += bsize(nxt);
            bset(prev, sz, 0);
            return prev;
        endfunction

        function bit grow(longint unsigned want, output int unsigned bp);
            longint unsigned words, sz;
            int unsigned nb;
            words = want >> 2;
            sz = ((words + 1) & ~64'd1) * 4;
            bp = 0;
            if (sz == 0 || sz > longint'(HeapBytes) - brk)
                return 0;
            nb = brk;
            bset(nb, int'(sz), 0);
            tag_wr(nb + int'(sz) - 4, 1);
            brk += int'(sz);
            bp = merge(nb);
            return 1;
        endfunction

        function void place(int unsigned bp, int unsigned asize);
            int unsigned have;
            have = bsize(bp);
            if (have - asize < 8)
                bset(bp, have, 1);
            else
            begin
                bset(bp, asize, 1);
                bset(bp + asize, have - asize, 0);
            end
        endfunction

        function void set_extend(bit [16:0] v);
            extend = v;
        endfunction

        // works out the result of one accepted item and updates the heap
        function void note_item(bit op, bit [16:0] req_bytes, bit [15:0] addr);
            heap_result_t r;
            int unsigned bp;
            longint unsigned asize, want;
            bit found;
            r.addr = '0;
            r.status = ST_DONE;
            found = 0;
            if (op == OP_ALLOC)
            begin
                if (req_bytes == 0)
                    r.status = ST_ZERO;
                else
                begin
                    asize = (req_bytes <= 8) ? 16 : ((longint'(req_bytes) + 15) / 8) * 8;
                    bp = 16;
                    while (bp < brk && bsize(bp) != 0)
                    begin
                        if (!bused(bp) && bsize(bp) >= asize)
                        begin
                            found = 1;
                            break;
                        end
                        bp += bsize(bp);
                    end
                    if (!found)
                    begin
                        want = (asize > extend) ? asize : longint'(extend);
                        found = grow(want, bp);
                    end
                    if (found)
                    begin
                        place(bp, int'(asize));
                        r.addr = bp[15:0];
                        live_blocks.push_back(bp[15:0]);
                        last_alloc = bp[15:0];
                    end
                    else
                        r.status = ST_OOM;
                end
            end
            else
            begin
                bp = 16;
                while (bp < brk && bsize(bp) != 0)
                begin
                    if (bp == addr)
                    begin
                        if (bused(bp))
                        begin
                            bset(bp, bsize(bp), 0);
                            void'(merge(bp));
                            foreach (live_blocks[i])
                                if (live_blocks[i] == addr)
                                begin
                                    live_blocks.delete(i);
                                    break;
                                end
                        end
                        break;
                    end
                    if (bp > addr)
                        break;
                    bp += bsize(bp);
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] addr, logic [1:0] status);
            heap_result_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result addr %h status %0d", $time, addr, status);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (addr !== e.addr)
            begin
                $display("%0t: payload_address expected %h actual %h", $time, e.addr, addr);
                errors++;
            end
            if (status !== e.status)
            begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    heap_scoreboard sb;
    bit no_idle;
    int rsp_stall = 0;
    int idle_cycles = 0;

    ilha_req_if req_if();
    ilha_rsp_if rsp_if();
    ilha_cfg_if cfg_if();

    implicit_list_heap_allocator uut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_if),
        .rsp(rsp_if),
        .cfg(cfg_if)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_item(bit op, bit [16:0] req_bytes, bit [15:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.op <= op;
        req_if.request_bytes <= req_bytes;
        req_if.block_address <= addr;
        do @(posedge clk); while (!req_if.ready);
        sb.note_item(op, req_bytes, addr);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_extend(bit [16:0] v);
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data <= v;
        do @(posedge clk); while (!cfg_if.ready);
        sb.set_extend(v);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic alloc_item(bit [16:0] n);
        send_item(OP_ALLOC, n, '0);
    endtask

    task automatic free_item(bit [15:0] a);
        send_item(OP_FREE, '0, a);
    endtask

    task automatic random_item();
        int r;
        int sz_sel;
        bit [16:0] n;
        r = $urandom_range(0, 99);
        if (sb.live_blocks.size() > 120)
            r = (r < 70) ? 60 : r;
        if (r < 55)
        begin
            sz_sel = $urandom_range(0, 99);
            if (sz_sel < 60)
                n = 17'($urandom_range(1, 64));
            else if (sz_sel < 85)
                n = 17'($urandom_range(65, 512));
            else if (sz_sel < 97)
                n = 17'($urandom_range(513, 4096));
            else
                n = 17'($urandom_range(4097, 65536));
            alloc_item(n);
        end
        else if (r < 90 && sb.live_blocks.size() > 0)
            free_item(sb.live_blocks[$urandom_range(0, sb.live_blocks.size() - 1)]);
        else if (r < 96)
            free_item(16'($urandom_range(0, 65535)));
        else
            alloc_item(17'd0);
    endtask

    // result side with random back-pressure
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.payload_address, rsp_if.status);
        if (rsp_stall > 0)
        begin
            rsp_stall <= rsp_stall - 1;
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            if (!no_idle)
                rsp_stall <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        bit [15:0] a, b, c, d, e;
        bit [16:0] ext_vals[4];
        sb = new();
        no_idle = 1'b0;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.op <= OP_ALLOC;
        req_if.request_bytes <= '0;
        req_if.block_address <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes and size rounding
        alloc_item(17'd0);
        alloc_item(17'd1);
        alloc_item(17'd8);
        alloc_item(17'd9);
        alloc_item(17'd17);
        alloc_item(17'd65536);
        alloc_item(17'h1ffff);
        // coalescing: neither, next only, both neighbors free
        alloc_item(17'd16); a = sb.last_alloc;
        alloc_item(17'd24); b = sb.last_alloc;
        alloc_item(17'd32); c = sb.last_alloc;
        alloc_item(17'd40); d = sb.last_alloc;
        alloc_item(17'd48); e = sb.last_alloc;
        free_item(b);
        free_item(a);
        free_item(d);
        free_item(c);
        // previous allocated, next free
        alloc_item(17'd100); a = sb.last_alloc;
        alloc_item(17'd100); b = sb.last_alloc;
        free_item(a);
        free_item(b);
        // bad frees: double free, mid block, outside heap; then e is freed
        free_item(b);
        free_item(e + 16'd8);
        free_item(16'hffff);
        free_item(e);
        // growth beyond the initial block
        alloc_item(17'd6000);

        ext_vals[0] = 17'd8;
        ext_vals[1] = 17'd65536;
        ext_vals[2] = 17'd4096;
        ext_vals[3] = 17'($urandom_range(8, 65536));
        for (int ph = 0; ph < 4; ph++)
        begin
            write_extend(ext_vals[ph]);
            for (int i = 0; i < RandomItems / 4; i++)
            begin
                if (i % 100 == 0)
                    no_idle = ($urandom_range(0, 3) == 0);
                if (i == 200)
                    wait_drained();
                random_item();
            end
            no_idle = 1'b0;
        end

        req_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
